FILE: design/wbls_pkg.sv
// Package: types, reset values and drive clamp shared by the load sequencer files.
`default_nettype none

package wbls_pkg;

    localparam int DRIVE_WIDTH = 16;
    localparam int CALC_WIDTH = 33;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH = 16;
    localparam int COUNT_WIDTH = 16;
    localparam int BRAKE_POWER_WIDTH = 15;

    typedef logic signed [CALC_WIDTH-1:0] drive_calc_t;
    typedef logic signed [DRIVE_WIDTH-1:0] drive_t;

    localparam drive_calc_t FULL_SCALE = drive_calc_t'(1) <<< (DRIVE_WIDTH - 2);

    localparam logic signed [15:0] LOADER_POWER_RESET = 16'sd16384;
    localparam logic [BRAKE_POWER_WIDTH-1:0] BRAKE_POWER_RESET = 15'd16384;
    localparam logic signed [15:0] HOLD_BACK_POWER_RESET = -16'sd1638;
    localparam logic [COUNT_WIDTH-1:0] UNWIND_TICKS_RESET = 16'd2000;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_LOADER_POWER    = 2'd0,
        CFG_BRAKE_POWER     = 2'd1,
        CFG_HOLD_BACK_POWER = 2'd2,
        CFG_UNWIND_TICKS    = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        MODE_UNKNOWN = 3'd0,
        MODE_RESET   = 3'd1,
        MODE_WIND    = 3'd2,
        MODE_BRAKE   = 3'd3,
        MODE_UNWIND  = 3'd4,
        MODE_LOADED  = 3'd5,
        MODE_SHOOT   = 3'd6
    } mode_t;

    typedef struct packed {
        logic shoot_request;
        logic retract_switch;
        logic brake_on_switch;
        logic brake_off_switch;
    } in_item_t;

    typedef struct packed {
        logic signed [DRIVE_WIDTH-1:0] winch_drive;
        logic signed [DRIVE_WIDTH-1:0] brake_drive;
        logic [2:0]                    mode_code;
        logic                          firing;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0]            loader_power;
        logic [BRAKE_POWER_WIDTH-1:0]  brake_power;
        logic signed [15:0]            hold_back_power;
        logic [COUNT_WIDTH-1:0]        unwind_ticks;
    } cfg_t;

    typedef struct packed {
        mode_t                  mode;
        logic [COUNT_WIDTH-1:0] countdown;
        drive_t                 winch_cmd;
        drive_t                 brake_cmd;
    } seq_state_t;

    function automatic drive_t clamp_drive(input drive_calc_t v);
        drive_calc_t c;
        begin
            c = v;
            if (v > FULL_SCALE)
            begin
                c = FULL_SCALE;
            end
            else if (v < -FULL_SCALE)
            begin
                c = -FULL_SCALE;
            end
            return c[DRIVE_WIDTH-1:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: design/wbls_cfg_regs.sv
// Configuration register file of the load sequencer.
`default_nettype none

module wbls_cfg_regs (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    input  wire logic [wbls_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [wbls_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output wbls_pkg::cfg_t                            cfg
);

    wbls_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.loader_power    <= wbls_pkg::LOADER_POWER_RESET;
            cfg_reg.brake_power     <= wbls_pkg::BRAKE_POWER_RESET;
            cfg_reg.hold_back_power <= wbls_pkg::HOLD_BACK_POWER_RESET;
            cfg_reg.unwind_ticks    <= wbls_pkg::UNWIND_TICKS_RESET;
        end
        else if (cfg_valid)
        begin
            case (wbls_pkg::cfg_index_t'(cfg_index))
                wbls_pkg::CFG_LOADER_POWER:
                    cfg_reg.loader_power <= $signed(cfg_data[15:0]);
                wbls_pkg::CFG_BRAKE_POWER:
                    cfg_reg.brake_power <= cfg_data[wbls_pkg::BRAKE_POWER_WIDTH-1:0];
                wbls_pkg::CFG_HOLD_BACK_POWER:
                    cfg_reg.hold_back_power <= $signed(cfg_data[15:0]);
                wbls_pkg::CFG_UNWIND_TICKS:
                    cfg_reg.unwind_ticks <= cfg_data[wbls_pkg::COUNT_WIDTH-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: design/wbls_step.sv
// Next mode, countdown and drive commands for one control tick.
`default_nettype none

module wbls_step (
    input  wire wbls_pkg::cfg_t       cfg,
    input  wire wbls_pkg::seq_state_t cur,
    input  wire wbls_pkg::in_item_t   item,
    output wbls_pkg::seq_state_t      nxt
);

    logic shoot;
    logic wound;
    logic braked;
    logic unbraked;
    logic [wbls_pkg::COUNT_WIDTH-1:0] count_dec;
    wbls_pkg::drive_t brake_fwd;
    wbls_pkg::drive_t brake_rev;
    wbls_pkg::drive_t loader_drv;
    wbls_pkg::drive_t hold_drv;
    wbls_pkg::mode_t mode_next;

    assign shoot    = item.shoot_request;
    assign wound    = !item.retract_switch;
    assign braked   = item.brake_on_switch;
    assign unbraked = item.brake_off_switch;

    assign count_dec = (cur.countdown != '0) ? cur.countdown - 1'b1 : '0;

    assign brake_fwd  = wbls_pkg::clamp_drive(wbls_pkg::drive_calc_t'(cfg.brake_power));
    assign brake_rev  = wbls_pkg::clamp_drive(-wbls_pkg::drive_calc_t'(cfg.brake_power));
    assign loader_drv = wbls_pkg::clamp_drive(wbls_pkg::drive_calc_t'(cfg.loader_power));
    assign hold_drv   = wbls_pkg::clamp_drive(wbls_pkg::drive_calc_t'(cfg.hold_back_power));

    // next mode
    always_comb
    begin
        mode_next = cur.mode;
        case (cur.mode)
            wbls_pkg::MODE_RESET:
            begin
                if (unbraked)
                begin
                    mode_next = wbls_pkg::MODE_WIND;
                end
            end
            wbls_pkg::MODE_WIND:
            begin
                if (wound)
                begin
                    mode_next = wbls_pkg::MODE_BRAKE;
                end
            end
            wbls_pkg::MODE_BRAKE:
            begin
                if (braked)
                begin
                    mode_next = wbls_pkg::MODE_UNWIND;
                end
            end
            wbls_pkg::MODE_UNWIND:
            begin
                if (count_dec == '0)
                begin
                    mode_next = wbls_pkg::MODE_LOADED;
                end
            end
            wbls_pkg::MODE_LOADED:
            begin
                if (shoot)
                begin
                    mode_next = wbls_pkg::MODE_SHOOT;
                end
            end
            wbls_pkg::MODE_SHOOT:
            begin
                if (unbraked)
                begin
                    mode_next = wbls_pkg::MODE_WIND;
                end
            end
            default:
            begin
                if (braked)
                begin
                    mode_next = wound ? wbls_pkg::MODE_UNWIND : wbls_pkg::MODE_LOADED;
                end
                else if (unbraked)
                begin
                    mode_next = wbls_pkg::MODE_WIND;
                end
                else
                begin
                    mode_next = wbls_pkg::MODE_RESET;
                end
            end
        endcase
    end

    // countdown and drives
    always_comb
    begin
        nxt.mode      = mode_next;
        nxt.countdown = cur.countdown;
        nxt.winch_cmd = cur.winch_cmd;
        nxt.brake_cmd = cur.brake_cmd;
        case (cur.mode)
            wbls_pkg::MODE_RESET:
            begin
                nxt.brake_cmd = unbraked ? '0 : brake_fwd;
            end
            wbls_pkg::MODE_WIND:
            begin
                nxt.winch_cmd = wound ? hold_drv : loader_drv;
            end
            wbls_pkg::MODE_BRAKE:
            begin
                nxt.brake_cmd = braked ? '0 : brake_fwd;
                if (braked)
                begin
                    nxt.countdown = cfg.unwind_ticks;
                end
            end
            wbls_pkg::MODE_UNWIND:
            begin
                nxt.countdown = count_dec;
                nxt.winch_cmd = (count_dec == '0) ? '0 : brake_rev;
            end
            wbls_pkg::MODE_SHOOT:
            begin
                nxt.brake_cmd = unbraked ? '0 : brake_rev;
            end
            default:
            begin
                nxt.countdown = cur.countdown;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/winch_brake_load_sequencer_top.sv
// Top level of the winch and brake load sequencer.
//
// Input channel: in_valid, in_stall, in_item carry one control tick (shoot
// request and three limit-switch levels). An item is taken on a rising edge
// with in_valid high and in_stall low.
// Output channel: out_valid, out_stall, out_item carry one result per tick:
// held winch and brake drives (signed Q2.14), the new mode and a firing flag.
// Configuration: cfg_valid, cfg_ready, cfg_index, cfg_data write the four
// registers (loader, brake and hold-back power, unwind ticks); cfg_ready is
// always high. Write only while no item is in flight.
// From input to result an item passes an input register, then the mode
// update into the result register. One item is taken every cycle while
// the output is not stalled; the mode update is a combinational step.
// When out_stall holds a waiting result, the result register and the input
// register both hold and in_stall rises once the input register is full.
// Reset clears the mode to unknown, the countdown and both drives to zero,
// loads the register reset values and empties both pipeline registers.
`default_nettype none

module winch_brake_load_sequencer_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output      logic                                 in_stall,
    input  wire wbls_pkg::in_item_t                   in_item,
    output      logic                                 out_valid,
    input  wire logic                                 out_stall,
    output wbls_pkg::out_item_t                       out_item,
    input  wire logic                                 cfg_valid,
    output      logic                                 cfg_ready,
    input  wire logic [wbls_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [wbls_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    wbls_pkg::cfg_t       cfg;
    wbls_pkg::seq_state_t state_reg;
    wbls_pkg::seq_state_t state_next;
    wbls_pkg::in_item_t   in_item_reg;
    wbls_pkg::out_item_t  out_item_reg;
    logic                 in_valid_reg;
    logic                 out_valid_reg;
    logic                 out_advance;
    logic                 in_advance;

    assign cfg_ready = 1'b1;

    wbls_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wbls_step u_step (
        .cfg  (cfg),
        .cur  (state_reg),
        .item (in_item_reg),
        .nxt  (state_next)
    );

    assign out_advance = !out_valid_reg || !out_stall;
    assign in_advance  = !in_valid_reg || out_advance;
    assign in_stall    = !in_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_advance)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_advance && in_valid)
        begin
            in_item_reg <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg       <= 1'b0;
            state_reg.mode      <= wbls_pkg::MODE_UNKNOWN;
            state_reg.countdown <= '0;
            state_reg.winch_cmd <= '0;
            state_reg.brake_cmd <= '0;
        end
        else if (out_advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_advance && in_valid_reg)
        begin
            out_item_reg.winch_drive <= state_next.winch_cmd;
            out_item_reg.brake_drive <= state_next.brake_cmd;
            out_item_reg.mode_code   <= state_next.mode;
            out_item_reg.firing      <= (state_next.mode == wbls_pkg::MODE_SHOOT);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the winch and brake load sequencer: predicts every result item.
module testbench;

    localparam int FULL_DRIVE = 1 << (wbls_pkg::DRIVE_WIDTH - 2);
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_PHASES = 9;
    localparam int TICKS_PER_PHASE = 158;
    localparam int HOLD_OFF_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    wbls_pkg::in_item_t in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    wbls_pkg::out_item_t out_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [wbls_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [wbls_pkg::CFG_DATA_WIDTH-1:0] cfg_data = '0;

    // predictor copy of the registers and sequencer state
    logic signed [15:0] loader_pw = 16'sd16384;
    logic [14:0] brake_pw = 15'd16384;
    logic signed [15:0] hold_pw = -16'sd1638;
    logic [15:0] unwind_len = 16'd2000;
    wbls_pkg::mode_t seq_mode = wbls_pkg::MODE_UNKNOWN;
    logic [15:0] unwind_left = '0;
    wbls_pkg::drive_t winch_held = '0;
    wbls_pkg::drive_t brake_held = '0;

    wbls_pkg::in_item_t pending_ticks[$];
    wbls_pkg::out_item_t predicted_drives[$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic holding = 1'b0;
    int mismatches = 0;
    int ticks_sent = 0;
    int results_checked = 0;
    int settings_written = 0;
    int cycle_count = 0;

    winch_brake_load_sequencer_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic wbls_pkg::drive_t saturate(input int v);
        if (v > FULL_DRIVE)
        begin
            return wbls_pkg::drive_t'(FULL_DRIVE);
        end
        if (v < -FULL_DRIVE)
        begin
            return wbls_pkg::drive_t'(-FULL_DRIVE);
        end
        return wbls_pkg::drive_t'(v);
    endfunction

    function automatic wbls_pkg::out_item_t sequence_tick(input wbls_pkg::in_item_t t);
        logic wound;
        logic braked;
        logic unbraked;
        int bp;
        wbls_pkg::out_item_t r;
        wound = !t.retract_switch;
        braked = t.brake_on_switch;
        unbraked = t.brake_off_switch;
        bp = int'(brake_pw);
        case (seq_mode)
            wbls_pkg::MODE_RESET:
            begin
                brake_held = saturate(bp);
                if (unbraked)
                begin
                    brake_held = '0;
                    seq_mode = wbls_pkg::MODE_WIND;
                end
            end
            wbls_pkg::MODE_WIND:
            begin
                winch_held = saturate(int'(loader_pw));
                if (wound)
                begin
                    winch_held = saturate(int'(hold_pw));
                    seq_mode = wbls_pkg::MODE_BRAKE;
                end
            end
            wbls_pkg::MODE_BRAKE:
            begin
                brake_held = saturate(bp);
                if (braked)
                begin
                    brake_held = '0;
                    unwind_left = unwind_len;
                    seq_mode = wbls_pkg::MODE_UNWIND;
                end
            end
            wbls_pkg::MODE_UNWIND:
            begin
                winch_held = saturate(-bp);
                if (unwind_left != 0)
                begin
                    unwind_left = unwind_left - 1'b1;
                end
                if (unwind_left == 0)
                begin
                    winch_held = '0;
                    seq_mode = wbls_pkg::MODE_LOADED;
                end
            end
            wbls_pkg::MODE_LOADED:
            begin
                if (t.shoot_request)
                begin
                    seq_mode = wbls_pkg::MODE_SHOOT;
                end
            end
            wbls_pkg::MODE_SHOOT:
            begin
                brake_held = saturate(-bp);
                if (unbraked)
                begin
                    brake_held = '0;
                    seq_mode = wbls_pkg::MODE_WIND;
                end
            end
            default:
            begin
                if (braked)
                begin
                    seq_mode = wound ? wbls_pkg::MODE_UNWIND : wbls_pkg::MODE_LOADED;
                end
                else if (unbraked)
                begin
                    seq_mode = wbls_pkg::MODE_WIND;
                end
                else
                begin
                    seq_mode = wbls_pkg::MODE_RESET;
                end
            end
        endcase
        r.winch_drive = winch_held;
        r.brake_drive = brake_held;
        r.mode_code = seq_mode;
        r.firing = (seq_mode == wbls_pkg::MODE_SHOOT);
        return r;
    endfunction

    always @(posedge clk)
    begin
        logic took;
        if (rst_n)
        begin
            took = in_valid && !in_stall;
            if (took)
            begin
                predicted_drives.push_back(sequence_tick(in_item));
            end
            // hold a stalled item
            if (!(in_valid && !took))
            begin
                if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_item <= pending_ticks.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        wbls_pkg::out_item_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted_drives.size() == 0)
                begin
                    $display("%0t: expected no item, got %p", $time, out_item);
                    mismatches++;
                end
                else
                begin
                    want = predicted_drives.pop_front();
                    results_checked++;
                    if (out_item.winch_drive !== want.winch_drive)
                    begin
                        $display("%0t: winch_drive expected %0d, got %0d",
                                 $time, want.winch_drive, out_item.winch_drive);
                        mismatches++;
                    end
                    if (out_item.brake_drive !== want.brake_drive)
                    begin
                        $display("%0t: brake_drive expected %0d, got %0d",
                                 $time, want.brake_drive, out_item.brake_drive);
                        mismatches++;
                    end
                    if (out_item.mode_code !== want.mode_code)
                    begin
                        $display("%0t: mode_code expected %0d, got %0d",
                                 $time, want.mode_code, out_item.mode_code);
                        mismatches++;
                    end
                    if (out_item.firing !== want.firing)
                    begin
                        $display("%0t: firing expected %0b, got %0b",
                                 $time, want.firing, out_item.firing);
                        mismatches++;
                    end
                end
            end
            out_stall <= holding || ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic push_tick(input int s, input int r, input int on, input int off);
        wbls_pkg::in_item_t t;
        t.shoot_request = s[0];
        t.retract_switch = r[0];
        t.brake_on_switch = on[0];
        t.brake_off_switch = off[0];
        pending_ticks.push_back(t);
        ticks_sent++;
    endtask

    task automatic push_random_tick();
        push_tick($urandom_range(0, 1), $urandom_range(0, 1),
                  $urandom_range(0, 1), $urandom_range(0, 1));
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_ticks.size() != 0 || in_valid || predicted_drives.size() != 0);
    endtask

    task automatic write_reg(input wbls_pkg::cfg_index_t idx, input logic [15:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic load_settings(input logic signed [15:0] lp, input logic [14:0] bp,
                                 input logic signed [15:0] hp, input logic [15:0] ut);
        @(posedge clk);
        write_reg(wbls_pkg::CFG_LOADER_POWER, lp);
        write_reg(wbls_pkg::CFG_BRAKE_POWER, {1'($urandom_range(0, 1)), bp});
        write_reg(wbls_pkg::CFG_HOLD_BACK_POWER, hp);
        write_reg(wbls_pkg::CFG_UNWIND_TICKS, ut);
        cfg_valid <= 1'b0;
        loader_pw = lp;
        brake_pw = bp;
        hold_pw = hp;
        unwind_len = ut;
        settings_written++;
        @(negedge clk);
    endtask

    function automatic logic signed [15:0] pick_power();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd32767;
            3: return -16'sd32768;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [14:0] pick_brake();
        case ($urandom_range(0, 4))
            0: return 15'd0;
            1: return 15'd16384;
            2: return 15'd32767;
            default: return 15'($urandom_range(0, 32767));
        endcase
    endfunction

    initial
    begin
        send_idle_pct = 29;
        recv_idle_pct = 56;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // from unknown through reset, wind and brake on reset values
        push_tick(0, 1, 0, 0);
        push_tick(0, 1, 0, 0);
        push_tick(0, 1, 0, 1);
        push_tick(0, 1, 0, 0);
        push_tick(0, 0, 0, 0);
        push_tick(0, 0, 0, 0);
        wait_idle();

        // clamp every drive, zero-length unwind
        load_settings(-16'sd32768, 15'd32767, 16'sd32767, 16'd0);
        push_tick(0, 1, 1, 0);
        push_tick(0, 1, 0, 0);
        push_tick(1, 1, 0, 0);
        push_tick(0, 1, 0, 0);
        push_tick(0, 1, 0, 1);
        push_tick(0, 1, 0, 0);
        push_tick(0, 0, 0, 0);
        push_tick(0, 0, 0, 0);
        wait_idle();

        load_settings(-16'sd16384, 15'd32767, -16'sd32768, 16'd3);
        push_tick(0, 1, 1, 0);
        push_tick(1, 0, 0, 1);
        push_tick(1, 0, 1, 1);
        push_tick(1, 1, 1, 1);
        push_tick(0, 1, 1, 1);
        push_tick(1, 1, 0, 0);
        push_tick(0, 1, 0, 1);
        push_tick(0, 1, 1, 0);
        push_tick(0, 0, 1, 0);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 3)
            begin
                send_idle_pct = 56;
                recv_idle_pct = 29;
            end
            else if (p == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p == 0)
            begin
                load_settings(16'sd16384, 15'd0, 16'sd16384, 16'd1);
            end
            else
            begin
                load_settings(pick_power(), pick_brake(), pick_power(),
                              16'(($urandom_range(0, 3) == 0) ? $urandom_range(13, 40)
                                                              : $urandom_range(0, 12)));
            end
            if (p == 4)
            begin
                // pause the sender until the block has drained
                repeat (TICKS_PER_PHASE / 2) push_random_tick();
                wait_idle();
                repeat ($urandom_range(5, 20)) @(negedge clk);
                repeat (TICKS_PER_PHASE - TICKS_PER_PHASE / 2) push_random_tick();
            end
            else
            begin
                repeat (TICKS_PER_PHASE) push_random_tick();
            end
            if (p == 1)
            begin
                fork
                begin
                    holding <= 1'b1;
                    repeat (HOLD_OFF_CYCLES) @(posedge clk);
                    holding <= 1'b0;
                end
                join_none
            end
            wait_idle();
        end

        // advance into a maximum-length unwind and step through its start
        load_settings(pick_power(), pick_brake(), pick_power(), 16'hFFFF);
        while (!(seq_mode == wbls_pkg::MODE_UNWIND && unwind_left > 16'd60000))
        begin
            push_tick(1, 0, 1, 1);
            wait_idle();
        end
        repeat (20) push_random_tick();
        wait_idle();

        repeat (10) @(negedge clk);
        $display("Checked %0d result items from %0d ticks over %0d register settings,",
                 results_checked, ticks_sent, settings_written);
        $display("covering every mode, full-scale clamping, short unwinds and a 65535-tick countdown.");
        if (mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: files.f
design/wbls_pkg.sv
design/wbls_cfg_regs.sv
design/wbls_step.sv
design/winch_brake_load_sequencer_top.sv
tb/sv/testbench.sv
